@@ rtl/core/kabf_pkg.sv @@
// shared types, constants and helpers of the angle and gyro bias kalman filter
package kabf_pkg;

  // fraction bits of the gain words
  localparam int GAIN_FRAC = 30;

  // configuration register indexes
  localparam logic [1:0] CFG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] CFG_BIAS_NOISE  = 2'd1;
  localparam logic [1:0] CFG_MEAS_NOISE  = 2'd2;

  // configuration reset values, unsigned q0.32
  localparam logic [31:0] ANGLE_NOISE_RST = 32'd4294967;
  localparam logic [31:0] BIAS_NOISE_RST  = 32'd12884902;
  localparam logic [31:0] MEAS_NOISE_RST  = 32'd128849019;

  // covariance correction jobs, in the order they run
  localparam logic [1:0] JOB_P10 = 2'd0;
  localparam logic [1:0] JOB_P00 = 2'd1;
  localparam logic [1:0] JOB_P11 = 2'd2;
  localparam logic [1:0] JOB_P01 = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PRED_MUL,
    ST_PRED_WB,
    ST_P11_LO,
    ST_P11_HI,
    ST_P11_ACC,
    ST_CROSS_WB,
    ST_INNER_LO,
    ST_INNER_HI,
    ST_INNER_ACC,
    ST_P00_WB,
    ST_QB_MUL,
    ST_QB_WB,
    ST_K0_START,
    ST_K0_WAIT,
    ST_K1_START,
    ST_K1_WAIT,
    ST_ANG_MUL,
    ST_ANG_WB,
    ST_BIAS_MUL,
    ST_BIAS_WB,
    ST_UPD_LO,
    ST_UPD_HI,
    ST_UPD_ACC,
    ST_UPD_WB,
    ST_FIN
  } kabf_state_t;

  typedef enum logic {
    DV_IDLE,
    DV_RUN
  } kabf_div_state_t;

  typedef struct packed {
    logic               start;
    logic signed [47:0] num;
    logic signed [48:0] den;
  } kabf_div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
  } kabf_div_rsp_t;

  localparam logic signed [63:0] MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] MIN48 = -MAX48 - 64'sd1;
  localparam logic signed [63:0] MAX32 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] MIN32 = -MAX32 - 64'sd1;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > MAX48) r = MAX48;
    else if (v < MIN48) r = MIN48;
    else r = v;
    return r[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > MAX32) r = MAX32;
    else if (v < MIN32) r = MIN32;
    else r = v;
    return r[31:0];
  endfunction

endpackage

@@ rtl/core/kalman_angle_bias_filter_core.sv @@
// top level of the two-state angle and gyro bias kalman filter
// One beat on the input channel runs one filter update and yields one beat
// on the result channel. In a normal update a shared
// 33x33 signed multiplier with a registered product steps through the
// prediction, the covariance propagation and the corrections (the 48-bit
// covariance products go through it as two 24-bit halves), and the two gains
// come from one restoring divider at one quotient bit per cycle. The input is
// stalled while an update runs; a finished result waits in the output
// register, so the next beat may be taken while it is still stalled.
// Configuration writes are always ready and must only be issued while idle.
module kalman_angle_bias_filter_core (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [24:0] in_measured_angle,
  input  logic signed [24:0] in_gyro_rate,
  input  logic [15:0]        in_time_step,
  input  logic               in_force_angle,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_angle_estimate,
  output logic signed [31:0] out_bias_estimate
);
  import kabf_pkg::*;

  kabf_state_t state_r, state_nxt;

  // noise registers, unsigned q0.32
  logic [31:0] angq_r, biasq_r, measr_r;

  // filter state
  logic signed [31:0] ang_r, bias_r;
  logic signed [47:0] p00_r, p01_r, p10_r, p11_r;

  // captured beat
  logic signed [24:0] meas_r, rate_r;
  logic [15:0]        dt_r;

  // working registers
  logic signed [47:0] inner_r;
  logic signed [31:0] k0_r, k1_r, y_r;
  logic signed [65:0] prod_r;
  logic signed [81:0] acc_r;
  logic [1:0]         job_r;

  // output register
  logic               out_valid_r;
  logic signed [31:0] out_ang_r, out_bias_r;

  // shared multiplier operands
  logic signed [32:0] mul_a, mul_b;
  logic signed [32:0] dt33;
  logic signed [47:0] upd_p;
  logic signed [31:0] upd_k;

  kabf_div_req_t div_req;
  kabf_div_rsp_t div_rsp;

  logic in_fire, out_free;

  // writeback terms
  logic signed [63:0] t_cross, t_inner, t_upd, upd_tgt;

  assign in_fire = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign in_stall = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_angle_estimate = out_ang_r;
  assign out_bias_estimate = out_bias_r;

  kabf_gain_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_fire) state_nxt = in_force_angle ? ST_FIN : ST_PRED_MUL;
      ST_PRED_MUL:  state_nxt = ST_PRED_WB;
      ST_PRED_WB:   state_nxt = ST_P11_LO;
      ST_P11_LO:    state_nxt = ST_P11_HI;
      ST_P11_HI:    state_nxt = ST_P11_ACC;
      ST_P11_ACC:   state_nxt = ST_CROSS_WB;
      ST_CROSS_WB:  state_nxt = ST_INNER_LO;
      ST_INNER_LO:  state_nxt = ST_INNER_HI;
      ST_INNER_HI:  state_nxt = ST_INNER_ACC;
      ST_INNER_ACC: state_nxt = ST_P00_WB;
      ST_P00_WB:    state_nxt = ST_QB_MUL;
      ST_QB_MUL:    state_nxt = ST_QB_WB;
      ST_QB_WB:     state_nxt = ST_K0_START;
      ST_K0_START:  state_nxt = ST_K0_WAIT;
      ST_K0_WAIT:   if (div_rsp.done) state_nxt = ST_K1_START;
      ST_K1_START:  state_nxt = ST_K1_WAIT;
      ST_K1_WAIT:   if (div_rsp.done) state_nxt = ST_ANG_MUL;
      ST_ANG_MUL:   state_nxt = ST_ANG_WB;
      ST_ANG_WB:    state_nxt = ST_BIAS_MUL;
      ST_BIAS_MUL:  state_nxt = ST_BIAS_WB;
      ST_BIAS_WB:   state_nxt = ST_UPD_LO;
      ST_UPD_LO:    state_nxt = ST_UPD_HI;
      ST_UPD_HI:    state_nxt = ST_UPD_ACC;
      ST_UPD_ACC:   state_nxt = ST_UPD_WB;
      ST_UPD_WB:    state_nxt = (job_r == JOB_P01) ? ST_FIN : ST_UPD_LO;
      ST_FIN:       if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // covariance correction job: gain, source covariance and target
  always_comb begin
    unique case (job_r)
      JOB_P10: begin upd_k = k1_r; upd_p = p00_r; upd_tgt = 64'(p10_r); end
      JOB_P00: begin upd_k = k0_r; upd_p = p00_r; upd_tgt = 64'(p00_r); end
      JOB_P11: begin upd_k = k1_r; upd_p = p01_r; upd_tgt = 64'(p11_r); end
      JOB_P01: begin upd_k = k0_r; upd_p = p01_r; upd_tgt = 64'(p01_r); end
      default: begin upd_k = k0_r; upd_p = p01_r; upd_tgt = 64'(p01_r); end
    endcase
  end

  // sequencer outputs: multiplier operands and divider requests
  always_comb begin
    dt33 = 33'($signed({1'b0, dt_r}));
    mul_a = '0;
    mul_b = '0;
    div_req.start = 1'b0;
    div_req.num = p00_r;
    div_req.den = 49'(p00_r) + $signed(49'({measr_r, 8'd0}));
    unique case (state_r)
      ST_PRED_MUL: begin
        mul_a = dt33;
        mul_b = 33'(rate_r) - 33'(bias_r);
      end
      ST_P11_LO: begin
        mul_a = dt33;
        mul_b = 33'($signed({1'b0, p11_r[23:0]}));
      end
      ST_P11_HI: begin
        mul_a = dt33;
        mul_b = 33'($signed(p11_r[47:24]));
      end
      ST_INNER_LO: begin
        mul_a = dt33;
        mul_b = 33'($signed({1'b0, inner_r[23:0]}));
      end
      ST_INNER_HI: begin
        mul_a = dt33;
        mul_b = 33'($signed(inner_r[47:24]));
      end
      ST_QB_MUL: begin
        mul_a = dt33;
        mul_b = $signed({1'b0, biasq_r});
      end
      ST_K0_START: div_req.start = 1'b1;
      ST_K1_START: begin
        div_req.start = 1'b1;
        div_req.num = p10_r;
      end
      ST_ANG_MUL: begin
        mul_a = 33'(k0_r);
        mul_b = 33'(y_r);
      end
      ST_BIAS_MUL: begin
        mul_a = 33'(k1_r);
        mul_b = 33'(y_r);
      end
      ST_UPD_LO: begin
        mul_a = 33'(upd_k);
        mul_b = 33'($signed({1'b0, upd_p[23:0]}));
      end
      ST_UPD_HI: begin
        mul_a = 33'(upd_k);
        mul_b = 33'($signed(upd_p[47:24]));
      end
      default: ;
    endcase
  end

  // scaled products: dt*p11 and dt*inner are q8.40 after the 16-bit shift,
  // the gain products drop the 30 gain fraction bits
  assign t_cross = 64'($signed(acc_r[65:16]));
  assign t_inner = 64'($signed(acc_r[65:16]));
  assign t_upd = 64'($signed(acc_r[81:30]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      angq_r <= ANGLE_NOISE_RST;
      biasq_r <= BIAS_NOISE_RST;
      measr_r <= MEAS_NOISE_RST;
      ang_r <= '0;
      bias_r <= '0;
      p00_r <= '0;
      p01_r <= '0;
      p10_r <= '0;
      p11_r <= '0;
      job_r <= '0;
    end else begin
      state_r <= state_nxt;

      // configuration writes, indexes past the list are dropped
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ANGLE_NOISE: angq_r <= cfg_data;
          CFG_BIAS_NOISE:  biasq_r <= cfg_data;
          CFG_MEAS_NOISE:  measr_r <= cfg_data;
          default: ;
        endcase
      end

      // result register
      if (state_r == ST_FIN && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          // forced beat loads the angle and leaves the rest alone
          if (in_fire && in_force_angle) ang_r <= 32'(in_measured_angle);
          job_r <= JOB_P10;
        end
        ST_PRED_WB: ang_r <= sat32(64'(ang_r) + 64'($signed(prod_r[65:16])));
        ST_CROSS_WB: begin
          inner_r <= sat48(t_cross - 64'(p01_r) - 64'(p10_r)
                           + $signed(64'({angq_r, 8'd0})));
          p01_r <= sat48(64'(p01_r) - t_cross);
          p10_r <= sat48(64'(p10_r) - t_cross);
        end
        ST_P00_WB: p00_r <= sat48(64'(p00_r) + t_inner);
        ST_QB_WB: begin
          // bias noise is q8.40 after the shift by 8, so dt*q/2^16 is dt*q/2^8
          p11_r <= sat48(64'(p11_r) + $signed(64'(prod_r[65:8])));
          y_r <= sat32(64'(meas_r) - 64'(ang_r));
        end
        ST_K0_WAIT: if (div_rsp.done) k0_r <= div_rsp.quo;
        ST_K1_WAIT: if (div_rsp.done) k1_r <= div_rsp.quo;
        ST_ANG_WB:  ang_r <= sat32(64'(ang_r) + 64'($signed(prod_r[65:30])));
        ST_BIAS_WB: bias_r <= sat32(64'(bias_r) + 64'($signed(prod_r[65:30])));
        ST_UPD_WB: begin
          unique case (job_r)
            JOB_P10: p10_r <= sat48(upd_tgt - t_upd);
            JOB_P00: p00_r <= sat48(upd_tgt - t_upd);
            JOB_P11: p11_r <= sat48(upd_tgt - t_upd);
            JOB_P01: p01_r <= sat48(upd_tgt - t_upd);
            default: ;
          endcase
          job_r <= job_r + 2'd1;
        end
        default: ;
      endcase
    end

    // payload registers
    if (in_fire) begin
      meas_r <= in_measured_angle;
      rate_r <= in_gyro_rate;
      dt_r <= in_time_step;
    end

    prod_r <= mul_a * mul_b;

    // split products: low half first, then high half weighted by 2^24
    if (state_r == ST_P11_HI || state_r == ST_INNER_HI || state_r == ST_UPD_HI) begin
      acc_r <= 82'(prod_r);
    end else if (state_r == ST_P11_ACC || state_r == ST_INNER_ACC
                 || state_r == ST_UPD_ACC) begin
      acc_r <= acc_r + $signed({prod_r[57:0], 24'd0});
    end

    if (state_r == ST_FIN && out_free) begin
      out_ang_r <= ang_r;
      out_bias_r <= bias_r;
    end
  end

endmodule

@@ rtl/core/kabf_gain_div.sv @@
// restoring divider for the q1.30 kalman gains, one quotient bit per cycle
module kabf_gain_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kabf_pkg::kabf_div_req_t req,
  output kabf_pkg::kabf_div_rsp_t rsp
);
  import kabf_pkg::*;

  kabf_div_state_t    state_r, state_nxt;
  logic               neg_r, neg_nxt;
  logic [48:0]        ud_r, ud_nxt;
  logic [48:0]        rem_r, rem_nxt;
  logic [30:0]        mag_r, mag_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic signed [31:0] quo_r, quo_nxt;
  logic               done_r, done_nxt;

  logic [47:0] un;
  logic [48:0] ud;
  logic        q0;
  logic [49:0] rem2;
  logic        ge;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DV_IDLE: begin
        if (req.start && req.den != '0 && ({2'b00, un} < {ud, 1'b0})) state_nxt = DV_RUN;
      end
      DV_RUN: begin
        if (cnt_r == 5'(GAIN_FRAC - 1)) state_nxt = DV_IDLE;
      end
      default: state_nxt = DV_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    un = 48'(req.num[47] ? -req.num : req.num);
    ud = 49'(req.den[48] ? -req.den : req.den);
    q0 = {1'b0, un} >= ud;
    rem2 = {rem_r, 1'b0};
    ge = rem2 >= {1'b0, ud_r};
    neg_nxt = neg_r;
    ud_nxt = ud_r;
    rem_nxt = rem_r;
    mag_nxt = mag_r;
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    done_nxt = 1'b0;
    unique case (state_r)
      DV_IDLE: begin
        if (req.start) begin
          neg_nxt = req.num[47] ^ req.den[48];
          ud_nxt = ud;
          cnt_nxt = '0;
          if (req.den == '0) begin
            quo_nxt = '0;
            done_nxt = 1'b1;
          end else if ({2'b00, un} >= {ud, 1'b0}) begin
            quo_nxt = (req.num[47] ^ req.den[48]) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            done_nxt = 1'b1;
          end else begin
            rem_nxt = q0 ? ({1'b0, un} - ud) : {1'b0, un};
            mag_nxt = 31'(q0);
          end
        end
      end
      DV_RUN: begin
        rem_nxt = ge ? 49'(rem2 - {1'b0, ud_r}) : rem2[48:0];
        mag_nxt = {mag_r[29:0], ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(GAIN_FRAC - 1)) begin
          quo_nxt = neg_r ? -$signed({1'b0, mag_nxt}) : $signed({1'b0, mag_nxt});
          done_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    ud_r <= ud_nxt;
    rem_r <= rem_nxt;
    mag_r <= mag_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo = quo_r;

endmodule

@@ test/tb.sv @@
// self-checking testbench of the angle and gyro bias kalman filter core
`timescale 1ns / 100ps

module tb;
  import kabf_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic signed [24:0] meas;
    logic signed [24:0] rate;
    logic [15:0]        dt;
    logic               load_angle;
  } sample_t;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] bias;
  } estimate_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_ANGLE_NOISE;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [24:0] in_measured_angle = '0;
  logic signed [24:0] in_gyro_rate = '0;
  logic [15:0]        in_time_step = '0;
  logic               in_force_angle = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_angle_estimate;
  logic signed [31:0] out_bias_estimate;

  // filter copy kept by the testbench
  longint      mdl_angle, mdl_bias, mdl_p00, mdl_p01, mdl_p10, mdl_p11;
  logic [31:0] mdl_qa, mdl_qb, mdl_rm;

  estimate_t   pending_estimates[$];
  int          errors = 0;
  int          quiet_cycles = 0;
  bit          no_idle = 1'b0;
  int          hold_trig = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          stall_left = 0;

  kalman_angle_bias_filter_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_measured_angle  (in_measured_angle),
    .in_gyro_rate       (in_gyro_rate),
    .in_time_step       (in_time_step),
    .in_force_angle     (in_force_angle),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_angle_estimate (out_angle_estimate),
    .out_bias_estimate  (out_bias_estimate)
  );

  always #5 clk = ~clk;

  // clamp to a signed width
  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // q1.30 gain, truncated toward zero, saturated at magnitude two
  function automatic longint gain_of(input longint num, input longint den);
    bit          neg;
    longint      un, ud, mag;
    logic [127:0] wide;
    if (den == 0) return 0;
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    if (un / ud >= 2) begin
      mag = neg ? (longint'(1) <<< 31) : (longint'(1) <<< 31) - 1;
    end else begin
      wide = 128'(un) << GAIN_FRAC;
      wide = wide / 128'(ud);
      mag = longint'(wide[63:0]);
    end
    return neg ? -mag : mag;
  endfunction

  // floor of gain times covariance over 2^30, full width product
  function automatic longint gain_times_cov(input longint k, input longint p);
    logic signed [95:0] prod;
    prod = 96'(k);
    prod = prod * p;
    prod = prod >>> GAIN_FRAC;
    return longint'(prod[63:0]);
  endfunction

  // one filter update, returns the estimate the core should report
  function automatic estimate_t kalman_update(input sample_t s);
    longint meas, dt, rate, p11dt, inner, rsum, k0, k1, innov, p00, p01;
    longint qa, qb, rm;
    estimate_t e;
    meas = longint'(s.meas);
    dt = longint'(s.dt);
    if (s.load_angle) begin
      mdl_angle = meas;
    end else begin
      qa = longint'(mdl_qa) <<< 8;
      qb = longint'(mdl_qb) <<< 8;
      rm = longint'(mdl_rm) <<< 8;
      // predict
      rate = longint'(s.rate) - mdl_bias;
      mdl_angle = clamp(mdl_angle + ((dt * rate) >>> 16), 32);
      p11dt = (dt * mdl_p11) >>> 16;
      inner = clamp(p11dt - mdl_p01 - mdl_p10 + qa, 48);
      mdl_p00 = clamp(mdl_p00 + ((dt * inner) >>> 16), 48);
      mdl_p01 = clamp(mdl_p01 - p11dt, 48);
      mdl_p10 = clamp(mdl_p10 - p11dt, 48);
      mdl_p11 = clamp(mdl_p11 + ((qb * dt) >>> 16), 48);
      // gains from the innovation variance
      rsum = mdl_p00 + rm;
      k0 = gain_of(mdl_p00, rsum);
      k1 = gain_of(mdl_p10, rsum);
      // correct
      innov = clamp(meas - mdl_angle, 32);
      mdl_angle = clamp(mdl_angle + ((k0 * innov) >>> GAIN_FRAC), 32);
      mdl_bias = clamp(mdl_bias + ((k1 * innov) >>> GAIN_FRAC), 32);
      p00 = mdl_p00;
      p01 = mdl_p01;
      mdl_p00 = clamp(mdl_p00 - gain_times_cov(k0, p00), 48);
      mdl_p01 = clamp(mdl_p01 - gain_times_cov(k0, p01), 48);
      mdl_p10 = clamp(mdl_p10 - gain_times_cov(k1, p00), 48);
      mdl_p11 = clamp(mdl_p11 - gain_times_cov(k1, p01), 48);
    end
    e.angle = mdl_angle[31:0];
    e.bias = mdl_bias[31:0];
    return e;
  endfunction

  // register write, only issued while the core is idle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ANGLE_NOISE: mdl_qa = val;
      CFG_BIAS_NOISE:  mdl_qb = val;
      CFG_MEAS_NOISE:  mdl_rm = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_noises(input logic [31:0] qa, input logic [31:0] qb,
                              input logic [31:0] rm);
    write_reg(CFG_ANGLE_NOISE, qa);
    write_reg(CFG_BIAS_NOISE, qb);
    write_reg(CFG_MEAS_NOISE, rm);
  endtask

  // offer one input beat, with an optional gap in front of it
  task automatic drive_update(input sample_t s);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_measured_angle <= s.meas;
    in_gyro_rate <= s.rate;
    in_time_step <= s.dt;
    in_force_angle <= s.load_angle;
    do @(posedge clk); while (in_stall);
    pending_estimates.push_back(kalman_update(s));
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // sender pauses until every estimate is back
  task automatic wait_settled();
    release_input();
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  function automatic sample_t mk(input int meas, input int rate, input int dt,
                                 input bit ld);
    sample_t s;
    s.meas = 25'(meas);
    s.rate = 25'(rate);
    s.dt = 16'(dt);
    s.load_angle = ld;
    return s;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    if ($urandom_range(0, 7) != 0)
      s.meas = 25'(int'($urandom_range(0, 23592960)) - 11796480);
    else
      s.meas = 25'($urandom);
    if ($urandom_range(0, 1) != 0)
      s.rate = 25'(int'($urandom_range(0, 39321600)) - 19660800);
    else
      s.rate = 25'($urandom);
    case ($urandom_range(0, 7))
      0: s.dt = '0;
      1: s.dt = 16'hFFFF;
      2: s.dt = 16'($urandom);
      default: s.dt = 16'($urandom_range(1, 1000));
    endcase
    s.load_angle = ($urandom_range(0, 15) == 0);
    return s;
  endfunction

  // gains must be zero when the innovation variance is zero
  task automatic test_zero_variance();
    write_noises('0, '0, '0);
    drive_update(mk(11796480, 16777215, 65535, 1'b0));
    drive_update(mk(-11796480, -16777216, 65535, 1'b0));
    drive_update(mk(5000, 300, 0, 1'b0));
    wait_settled();
  endtask

  // forced angle, field extremes and zero time step
  task automatic test_forced_and_extremes();
    write_noises(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEAS_NOISE_RST);
    drive_update(mk(11796480, 0, 0, 1'b1));
    drive_update(mk(-11796480, -16777216, 65535, 1'b1));
    drive_update(mk(0, 0, 0, 1'b0));
    drive_update(mk(11796480, 16777215, 65535, 1'b0));
    drive_update(mk(-11796480, -16777216, 65535, 1'b0));
    drive_update(mk(-16777216, 16777215, 1, 1'b0));
    drive_update(mk(16777215, -16777216, 65535, 1'b1));
    drive_update(mk(-16777216, 0, 65535, 1'b0));
    drive_update(mk(1, -1, 66, 1'b0));
    wait_settled();
  endtask

  // largest noises drive the covariance into saturation
  task automatic test_noise_extremes();
    write_noises('1, '1, '1);
    repeat (6) drive_update(mk(16777215, 16777215, 65535, 1'b0));
    drive_update(mk(-16777216, -16777216, 65535, 1'b0));
    wait_settled();
    write_noises('1, '1, '0);
    repeat (4) drive_update(mk(-16777216, 16777215, 65535, 1'b0));
    wait_settled();
  endtask

  // receiver holds off long enough for the input to stall
  task automatic test_backpressure();
    write_noises(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEAS_NOISE_RST);
    @(posedge clk);
    hold_trig = hold_trig + 1;
    repeat (8) drive_update(random_sample());
    wait_settled();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_noises(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEAS_NOISE_RST);
        1: write_noises($urandom, $urandom, $urandom);
        2: write_noises($urandom_range(0, 1 << 24), $urandom_range(0, 1 << 24),
                        $urandom_range(0, 1 << 28));
        3: write_noises('1, $urandom, '0);
        4: write_noises('0, '0, $urandom);
        default: write_noises(ANGLE_NOISE_RST, $urandom, MEAS_NOISE_RST);
      endcase
      // final phase runs with no idling on either side
      no_idle = (ph == 5);
      repeat (305) drive_update(random_sample());
      wait_settled();
    end
  endtask

  // random stall bursts, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each result beat with the oldest estimate
  always @(posedge clk) begin
    estimate_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_estimates.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat angle=%0d bias=%0d", $time,
                 out_angle_estimate, out_bias_estimate);
      end else begin
        e = pending_estimates.pop_front();
        if (out_angle_estimate !== e.angle) begin
          errors++;
          $display("%0t: angle_estimate expected %0d actual %0d", $time,
                   e.angle, out_angle_estimate);
        end
        if (out_bias_estimate !== e.bias) begin
          errors++;
          $display("%0t: bias_estimate expected %0d actual %0d", $time,
                   e.bias, out_bias_estimate);
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("** kalman_angle_bias_filter_core: FAILED **");
      $finish;
    end
  end

  initial begin
    mdl_angle = 0;
    mdl_bias = 0;
    mdl_p00 = 0;
    mdl_p01 = 0;
    mdl_p10 = 0;
    mdl_p11 = 0;
    mdl_qa = ANGLE_NOISE_RST;
    mdl_qb = BIAS_NOISE_RST;
    mdl_rm = MEAS_NOISE_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_zero_variance();
    test_forced_and_extremes();
    test_noise_extremes();
    test_backpressure();
    test_random_phases();
    repeat (200) @(posedge clk);
    if (pending_estimates.size() != 0) begin
      errors++;
      $display("%0t: %0d estimates never arrived", $time, pending_estimates.size());
    end
    if (errors == 0)
      $display("** kalman_angle_bias_filter_core: PASSED **");
    else
      $display("** kalman_angle_bias_filter_core: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/kabf_pkg.sv
rtl/core/kabf_gain_div.sv
rtl/core/kalman_angle_bias_filter_core.sv
test/tb.sv
